[src/ptw_pkg.sv]
package ptw_pkg;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_PROTECT   = 2'd2,
    OP_UNMAP     = 2'd3
  } ptw_op_e;

  // Status codes of a result transaction.
  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_MISALIGNED      = 3'd1,
    ST_ABSENT          = 3'd2,
    ST_NO_PRESENT_FLAG = 3'd3,
    ST_OUTSIDE         = 3'd4
  } ptw_status_e;

  localparam logic [63:0] FRAME_BITS = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] FLAG_BITS  = 64'hfff0_0000_0000_0fff;
  localparam int unsigned IDX_BITS   = 9;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] virt_addr;
    logic [12:0] word_index;
    logic [63:0] word_data;
    logic [63:0] new_flags;
  } ptw_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] phys_addr;
  } ptw_out_t;

endpackage

[src/ptw_table_ram.sv]
module ptw_table_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/four_level_page_table_walker.sv]
// Four-level page-table walker with on-chip table memory.
// A raw write or a check that fails before the walk registers its result when accepted;
// a walk reads the four levels one after another through the one read port, and no new
// item is accepted until that walk has finished.
// Reset clears the table memory with a pass over all TABLE_PAGES * 512 words, one word a
// cycle, during which no input transaction is accepted; configuration writes are taken.
module four_level_page_table_walker #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ptw_pkg::ptw_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ptw_pkg::ptw_out_t out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [3:0]        cfg_data_i
);

  import ptw_pkg::*;

  // The memory holds TABLE_PAGES frames of 512 words; a word address is the frame
  // number followed by the nine index bits of the current level.
  localparam int unsigned FW          = $clog2(TABLE_PAGES);
  localparam int unsigned AW          = FW + IDX_BITS;
  localparam int unsigned TABLE_WORDS = TABLE_PAGES * 512;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [1:0]    lvl_q, lvl_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [3:0]    root_q, root_d;
  logic          out_valid_q, out_valid_d;
  ptw_out_t      out_q, out_d;
  ptw_out_t      res_q, res_d;
  ptw_in_t       item_q, item_d;
  logic [AW-1:0] slot_q, slot_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;

  logic          fin;
  ptw_out_t      fin_res;
  logic          out_free;
  logic [39:0]   next_frame;

  // Index of a level: level 0 uses address bits 47..39, level 3 uses 20..12.
  function automatic logic [IDX_BITS-1:0] level_index(logic [47:0] va, logic [1:0] lvl);
    logic [IDX_BITS-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [AW-1:0] word_addr(logic [39:0] frame, logic [IDX_BITS-1:0] idx);
    return {frame[FW-1:0], idx};
  endfunction

  function automatic logic frame_outside(logic [39:0] frame);
    return 64'(frame) >= 64'(TABLE_PAGES);
  endfunction

  ptw_table_ram #(
    .DEPTH (TABLE_WORDS),
    .AW    (AW)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Items enter only while the walker is idle; a finished result that cannot leave
  // yet is parked in the result register and the walker waits in the done state.
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign next_frame  = mem_rdata[51:12];

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    clr_d       = clr_q;
    root_d      = root_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    item_d      = item_q;
    slot_d      = slot_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = slot_q;
    fin         = 1'b0;
    fin_res     = '0;

    if (cfg_valid_i) begin
      root_d = cfg_data_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(TABLE_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_i;
          unique case (in_i.operation)
            OP_WRITE: begin
              fin = 1'b1;
              if (32'(in_i.word_index) < 32'(TABLE_WORDS)) begin
                mem_we         = 1'b1;
                mem_waddr      = AW'(in_i.word_index);
                mem_wdata      = in_i.word_data;
                fin_res.status = ST_OK;
              end else begin
                fin_res.status = ST_OUTSIDE;
              end
            end
            default: begin
              if (in_i.operation != OP_TRANSLATE && in_i.virt_addr[11:0] != '0) begin
                fin            = 1'b1;
                fin_res.status = ST_MISALIGNED;
              end else if (in_i.operation == OP_PROTECT && !in_i.new_flags[0]) begin
                fin            = 1'b1;
                fin_res.status = ST_NO_PRESENT_FLAG;
              end else if (frame_outside(40'(root_q))) begin
                fin            = 1'b1;
                fin_res.status = ST_OUTSIDE;
              end else begin
                // Start the walk with the top-level entry.
                mem_re    = 1'b1;
                mem_raddr = word_addr(40'(root_q), level_index(in_i.virt_addr, 2'd0));
                slot_d    = mem_raddr;
                lvl_d     = 2'd0;
                state_d   = S_WALK;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        // The entry read in the previous cycle is on the memory output now.
        if (!mem_rdata[0]) begin
          fin            = 1'b1;
          fin_res.status = ST_ABSENT;
        end else if (lvl_q != 2'd3) begin
          if (frame_outside(next_frame)) begin
            fin            = 1'b1;
            fin_res.status = ST_OUTSIDE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = word_addr(next_frame, level_index(item_q.virt_addr, lvl_q + 2'd1));
            slot_d    = mem_raddr;
            lvl_d     = lvl_q + 2'd1;
          end
        end else begin
          // Present leaf: the translation or the write-back goes to the same word.
          fin            = 1'b1;
          fin_res.status = ST_OK;
          unique case (item_q.operation)
            OP_TRANSLATE: begin
              fin_res.phys_addr = {next_frame, item_q.virt_addr[11:0]};
            end
            OP_PROTECT: begin
              mem_we    = 1'b1;
              mem_waddr = slot_q;
              mem_wdata = (mem_rdata & FRAME_BITS) | (item_q.new_flags & FLAG_BITS);
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = slot_q;
              mem_wdata = '0;
            end
          endcase
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_d       = fin_res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      lvl_q       <= 2'd0;
      clr_q       <= '0;
      root_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      clr_q       <= clr_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    res_q  <= res_d;
    item_q <= item_d;
    slot_q <= slot_d;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ptw_pkg::*;

  // The block is built with sixteen table frames of 512 entries each.
  localparam int unsigned PAGES       = 16;
  localparam int unsigned PAGE_WORDS  = 512;
  localparam int unsigned TABLE_WORDS = PAGES * PAGE_WORDS;

  // The clearing pass after reset covers all TABLE_WORDS words of the memory, and
  // this limit leaves a wide margin over what a correct run needs.
  localparam int unsigned CYCLE_LIMIT = 400_000;

  // Predicts the walker: it keeps a private copy of the table memory and of the
  // root frame, works out the result of every accepted transaction and checks the
  // results of the block in order against the oldest prediction.
  class walk_scoreboard;
    bit [63:0]   table_mem [TABLE_WORDS];
    bit [3:0]    root_frame;
    ptw_out_t    expected_q [$];
    int unsigned errors;

    static function logic [8:0] level_index(logic [47:0] va, int lvl);
      return va[12 + 9 * lvl +: 9];
    endfunction

    function void set_root(logic [3:0] frame);
      root_frame = frame;
    endfunction

    // Walks the three upper levels. On success slot holds the word of the leaf.
    function ptw_status_e locate_leaf(logic [47:0] va, output int unsigned slot);
      logic [39:0] frame;
      logic [63:0] entry;
      frame = 40'(root_frame);
      slot  = 0;
      for (int lvl = 3; lvl >= 1; lvl--) begin
        if (frame >= PAGES) return ST_OUTSIDE;
        entry = table_mem[int'(frame) * PAGE_WORDS + level_index(va, lvl)];
        if (!entry[0]) return ST_ABSENT;
        frame = entry[51:12];
      end
      if (frame >= PAGES) return ST_OUTSIDE;
      slot = int'(frame) * PAGE_WORDS + level_index(va, 0);
      return ST_OK;
    endfunction

    function ptw_out_t predict(ptw_in_t item);
      ptw_out_t    res;
      int unsigned slot;
      logic [63:0] leaf;
      res.status    = ST_OK;
      res.phys_addr = '0;
      case (item.operation)
        OP_WRITE: begin
          if (item.word_index < TABLE_WORDS) table_mem[item.word_index] = item.word_data;
          else res.status = ST_OUTSIDE;
        end
        OP_TRANSLATE: begin
          res.status = locate_leaf(item.virt_addr, slot);
          if (res.status == ST_OK) begin
            leaf = table_mem[slot];
            if (!leaf[0]) res.status = ST_ABSENT;
            else res.phys_addr = {leaf[51:12], item.virt_addr[11:0]};
          end
        end
        default: begin
          if (item.virt_addr[11:0] != '0) begin
            res.status = ST_MISALIGNED;
          end else if (item.operation == OP_PROTECT && !item.new_flags[0]) begin
            res.status = ST_NO_PRESENT_FLAG;
          end else begin
            res.status = locate_leaf(item.virt_addr, slot);
            if (res.status == ST_OK) begin
              leaf = table_mem[slot];
              if (!leaf[0]) res.status = ST_ABSENT;
              else if (item.operation == OP_PROTECT)
                table_mem[slot] = (leaf & FRAME_BITS) | (item.new_flags & FLAG_BITS);
              else table_mem[slot] = '0;
            end
          end
        end
      endcase
      return res;
    endfunction

    function void note_input(ptw_in_t item);
      expected_q.push_back(predict(item));
    endfunction

    function void check_result(ptw_out_t got);
      ptw_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d phys_addr %h", $time, got.status,
                 got.phys_addr);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
      end
      if (got.phys_addr !== want.phys_addr) begin
        errors++;
        $display("%0t: phys_addr expected %h, actual %h", $time, want.phys_addr,
                 got.phys_addr);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  ptw_in_t           in_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ptw_out_t          out_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [3:0]        cfg_data_i  = '0;

  walk_scoreboard    sb = new;

  // Stimulus state: idling odds in percent, the root frame now in force, a pool of
  // virtual pages whose walks were built complete, and the count of sent items.
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int                hold_off_left;
  int unsigned       items_sent;
  int unsigned       cycle_count;
  logic [3:0]        root_now;
  logic [47:0]       va_pool [$];

  four_level_page_table_walker #(
    .TABLE_PAGES(PAGES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Both handshakes are sampled here, in one process, so that a transaction is always
  // predicted before its own result is checked, even if both land on the same edge.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_input(in_i);
    if (out_valid_o && !out_stall_i) sb.check_result(out_o);
  end

  // Receiver side. A hold-off request keeps the output stalled for a counted number of
  // cycles; otherwise the stall is random at the odds of the current phase.
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A table entry pointing at frame, with random flag bits around it.
  function automatic logic [63:0] pte_value(logic [39:0] frame, bit present);
    logic [63:0] e;
    e        = rand64() & FLAG_BITS;
    e[51:12] = frame;
    e[0]     = present;
    return e;
  endfunction

  // Offers one transaction, after a random number of idle cycles, and returns at the
  // edge where it is accepted. Valid stays high so that the next item can follow
  // back to back; whoever comes next decides whether to lower it.
  task automatic send_item(ptw_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Fields that an operation does not use still carry random values.
  task automatic send_write(logic [12:0] widx, logic [63:0] data);
    ptw_in_t item;
    item.operation  = OP_WRITE;
    item.virt_addr  = 48'(rand64());
    item.word_index = widx;
    item.word_data  = data;
    item.new_flags  = rand64();
    send_item(item);
  endtask

  task automatic send_walk(ptw_op_e op, logic [47:0] va, logic [63:0] flags);
    ptw_in_t item;
    item.operation  = op;
    item.virt_addr  = va;
    item.word_index = 13'($urandom);
    item.word_data  = rand64();
    item.new_flags  = flags;
    send_item(item);
  endtask

  // Stops offering and waits until every predicted result has been checked.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Writes the root frame register. Only called while no transaction is outstanding.
  task automatic write_root(logic [3:0] frame);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= frame;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    root_now = frame;
    sb.set_root(frame);
  endtask

  // Writes the four entries that map the page of va through frames picked at random.
  // A broken chain stops at one level, either with an entry that is not present or
  // with an upper-level entry that points past the end of the table memory.
  task automatic build_chain(logic [47:0] va, bit broken);
    logic [39:0] tbl;
    logic [39:0] nxt;
    bit          present;
    int          bad;
    tbl = 40'(root_now);
    bad = broken ? int'($urandom_range(3)) : -1;
    for (int lvl = 3; lvl >= 0; lvl--) begin
      nxt     = (lvl == 0) ? 40'(rand64()) : 40'($urandom_range(PAGES - 1));
      present = 1'b1;
      if (lvl == bad) begin
        if (lvl == 0 || $urandom_range(1) == 0) present = 1'b0;
        else nxt = 40'(rand64()) | 40'(PAGES);
      end
      send_write(13'(tbl * PAGE_WORDS + walk_scoreboard::level_index(va, lvl)),
                 pte_value(nxt, present));
      if (lvl == bad) break;
      tbl = nxt;
    end
  endtask

  // Directed opening with the root frame at zero: every error code, every operation,
  // and the extremes of the address and entry fields.
  task automatic run_directed();
    // Empty tables, then the alignment and present-flag checks, alignment first.
    send_walk(OP_TRANSLATE, 48'h0000_0000_0abc, rand64());
    send_walk(OP_UNMAP, 48'h0000_0000_0001, rand64());
    send_walk(OP_PROTECT, 48'h0, 64'h0);
    send_walk(OP_PROTECT, 48'h0000_0000_0800, 64'h0);
    // A walk that stops at the second level, then a complete one whose leaf has every
    // frame bit set.
    send_write(13'd0, 64'h0000_0000_0000_1001);
    send_walk(OP_TRANSLATE, 48'h0, rand64());
    send_write(13'(1 * PAGE_WORDS), 64'h0000_0000_0000_2001);
    send_write(13'(2 * PAGE_WORDS), 64'h0000_0000_0000_3001);
    send_write(13'(3 * PAGE_WORDS), 64'hffff_ffff_ffff_ffff);
    send_walk(OP_TRANSLATE, 48'h0000_0000_0fff, rand64());
    // Protect keeps the frame and takes only the flag bits of new_flags.
    send_walk(OP_PROTECT, 48'h0, 64'h8000_0000_0000_0001);
    send_walk(OP_TRANSLATE, 48'h0, rand64());
    // Unmap clears the leaf; a second unmap finds it absent.
    send_walk(OP_UNMAP, 48'h0, rand64());
    send_walk(OP_TRANSLATE, 48'h0000_0000_0123, rand64());
    send_walk(OP_UNMAP, 48'h0, rand64());
    // A top-level entry that points past the table memory, reached through the
    // highest virtual address.
    send_write(13'd511, 64'h0000_0000_0001_0001);
    send_walk(OP_TRANSLATE, 48'hffff_ffff_ffff, rand64());
    // The last-level table frame is out of range: it is checked before the leaf read.
    send_write(13'd1, 64'h0000_0000_0000_4001);
    send_write(13'(4 * PAGE_WORDS), 64'h0000_0000_0000_5001);
    send_write(13'(5 * PAGE_WORDS), 64'h000f_ffff_ffff_f001);
    send_walk(OP_TRANSLATE, 48'h0080_0000_0000, rand64());
    send_walk(OP_PROTECT, 48'h0080_0000_0000, 64'hffff_ffff_ffff_ffff);
    // Highest word of the memory, then an absent entry at the second level.
    send_write(13'(TABLE_WORDS - 1), 64'hffff_ffff_ffff_ffff);
    send_walk(OP_TRANSLATE, 48'h007f_c000_0000, rand64());
  endtask

  // Random traffic. Most of it builds complete walks and then works on the pages
  // that were mapped; the rest is broken walks and items with every field random.
  task automatic run_random(int unsigned target);
    logic [47:0] va;
    logic [63:0] flags;
    int unsigned pick;
    int unsigned choice;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 30 || va_pool.size() == 0) begin
        va        = 48'(rand64());
        va[11:0]  = '0;
        if ($urandom_range(99) < 15) begin
          build_chain(va, 1'b1);
          send_walk(OP_TRANSLATE, va | 48'($urandom_range(4095)), rand64());
        end else begin
          build_chain(va, 1'b0);
          va_pool.push_back(va);
          if (va_pool.size() > 12) va_pool.delete(0);
        end
      end else if (pick < 88) begin
        va     = va_pool[$urandom_range(va_pool.size() - 1)];
        choice = $urandom_range(99);
        if (choice < 45) begin
          send_walk(OP_TRANSLATE, va | 48'($urandom_range(4095)), rand64());
        end else if (choice < 75) begin
          flags    = rand64();
          flags[0] = ($urandom_range(9) != 0);
          send_walk(OP_PROTECT, va, flags);
        end else if (choice < 85) begin
          send_walk(OP_UNMAP, va, rand64());
        end else if (choice < 92) begin
          send_walk($urandom_range(1) ? OP_PROTECT : OP_UNMAP,
                    va | 48'($urandom_range(4095, 1)), rand64());
        end else begin
          build_chain(va, 1'b0);
        end
      end else begin
        send_walk(ptw_op_e'($urandom_range(3)), 48'(rand64()), rand64());
      end
    end
  endtask

  initial begin
    logic [3:0] roots [4];
    roots = '{4'd15, 4'($urandom_range(14, 1)), 4'd0, 4'($urandom_range(15))};
    idle_pct      = 0;
    stall_pct     = 0;
    hold_off_left = 0;
    items_sent    = 0;
    cycle_count   = 0;
    root_now      = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The register is taken during the clearing pass; items wait until it ends.
    write_root(4'd0);
    run_directed();

    // Four phases of random traffic, each with its own idling pattern and root frame.
    // The register is only written after every outstanding result has come back.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      write_root(roots[ph]);
      va_pool.delete();
      // In the first phase the receiver holds off for a long stretch while items
      // keep coming, so the walker fills up and stalls its input.
      if (ph == 0) hold_off_left = 400;
      run_random(items_sent + 356);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
